FILE: rtl/vtpe_pkg.sv
package vtpe_pkg;

	// Input command codes
	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_END   = 2'd1,
		CMD_POINT = 2'd2,
		CMD_NONE  = 2'd3
	} cmd_t;

	localparam int MAX_BYTES = 5;

	// One queued job: up to five terminal bytes and how many are used
	typedef struct packed {
		logic [MAX_BYTES-1:0][7:0] bytes;
		logic [2:0]                count;
	} job_t;

	// Terminal characters and address offsets
	localparam logic [7:0] CH_ESC   = 8'd27;
	localparam logic [7:0] CH_FS    = 8'd28;
	localparam logic [7:0] CH_NL    = 8'd10;
	localparam logic [7:0] HI_OFS   = 8'd32;
	localparam logic [7:0] LOY_OFS  = 8'd96;
	localparam logic [7:0] LOX_OFS  = 8'd64;
	localparam logic [7:0] INT_ZERO = 8'd64;
	localparam logic [7:0] INT_NEG  = 8'd70;
	localparam logic [7:0] INT_MAX  = 8'd119;
	localparam logic [8:0] LADDER_TOP = 9'd94;

	// Intensity ladder, indexed by the brightness rounded up to a whole step
	function automatic logic [7:0] ladder_code(input logic [6:0] lvl);
		logic [7:0] code;
		case (lvl) inside
			[7'd0:7'd1]:   code = 8'd70;
			7'd2:          code = 8'd75;
			7'd3:          code = 8'd79;
			7'd4:          code = 8'd82;
			7'd5:          code = 8'd85;
			7'd6:          code = 8'd87;
			7'd7:          code = 8'd88;
			7'd8:          code = 8'd89;
			7'd9:          code = 8'd90;
			7'd10:         code = 8'd91;
			7'd11:         code = 8'd92;
			7'd12:         code = 8'd94;
			7'd13:         code = 8'd95;
			7'd14:         code = 8'd96;
			[7'd15:7'd16]: code = 8'd97;
			7'd17:         code = 8'd98;
			[7'd18:7'd19]: code = 8'd99;
			7'd20:         code = 8'd100;
			[7'd21:7'd22]: code = 8'd101;
			7'd23:         code = 8'd102;
			[7'd24:7'd25]: code = 8'd103;
			[7'd26:7'd28]: code = 8'd104;
			[7'd29:7'd31]: code = 8'd105;
			[7'd32:7'd34]: code = 8'd106;
			[7'd35:7'd38]: code = 8'd107;
			[7'd39:7'd41]: code = 8'd108;
			[7'd42:7'd44]: code = 8'd109;
			[7'd45:7'd47]: code = 8'd110;
			[7'd48:7'd50]: code = 8'd111;
			[7'd51:7'd56]: code = 8'd112;
			[7'd57:7'd62]: code = 8'd113;
			[7'd63:7'd69]: code = 8'd114;
			[7'd70:7'd75]: code = 8'd115;
			[7'd76:7'd81]: code = 8'd116;
			[7'd82:7'd88]: code = 8'd117;
			[7'd89:7'd94]: code = 8'd118;
			default:       code = INT_MAX;
		endcase
		return code;
	endfunction

endpackage

FILE: rtl/vtpe_front.sv
module vtpe_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [9:0]         x_coord,
	input  logic [9:0]         y_coord,
	input  logic signed [12:0] intensity,
	output logic               push_valid,
	input  logic               push_ready,
	output vtpe_pkg::job_t     push_job
);
	import vtpe_pkg::*;

	logic [9:0] last_x_q;
	logic [9:0] last_y_q;
	cmd_t       cmd;
	logic       accept;
	logic       hx, hy, ly;
	logic [8:0] lvl;
	logic [7:0] int_code;

	assign cmd        = cmd_t'(command);
	assign in_ready   = push_ready;
	assign push_valid = in_valid && (cmd != CMD_NONE);
	assign accept     = in_valid && in_ready;

	// Round brightness up to whole steps and look up its character
	always_comb begin
		lvl = 9'(({1'b0, intensity[11:0]} + 13'd15) >> 4);
		if (intensity[12])
			int_code = INT_NEG;
		else if (intensity == 13'sd0)
			int_code = INT_ZERO;
		else if (lvl > LADDER_TOP)
			int_code = INT_MAX;
		else
			int_code = ladder_code(lvl[6:0]);
	end

	// Compare against the last point
	assign hy = y_coord[9:5] != last_y_q[9:5];
	assign hx = x_coord[9:5] != last_x_q[9:5];
	assign ly = y_coord[4:0] != last_y_q[4:0];

	// Pack the byte list of this item
	always_comb begin
		logic [2:0] n;
		push_job = '0;
		n        = 3'd1;
		case (cmd)
			CMD_START: begin
				push_job.bytes[0] = CH_ESC;
				push_job.bytes[1] = CH_FS;
				n = 3'd2;
			end
			CMD_END: begin
				push_job.bytes[0] = CH_NL;
			end
			CMD_POINT: begin
				push_job.bytes[0] = int_code;
				if (hy) begin
					push_job.bytes[n] = {3'b000, y_coord[9:5]} + HI_OFS;
					n = n + 3'd1;
				end
				if (hx || ly) begin
					push_job.bytes[n] = {3'b000, y_coord[4:0]} + LOY_OFS;
					n = n + 3'd1;
				end
				if (hx) begin
					push_job.bytes[n] = {3'b000, x_coord[9:5]} + HI_OFS;
					n = n + 3'd1;
				end
				push_job.bytes[n] = {3'b000, x_coord[4:0]} + LOX_OFS;
				n = n + 3'd1;
			end
			default: begin
				n = 3'd1;
			end
		endcase
		push_job.count = n;
	end

	// Store the point once it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_x_q <= '0;
			last_y_q <= '0;
		end else if (accept && cmd == CMD_POINT) begin
			last_x_q <= x_coord;
			last_y_q <= y_coord;
		end
	end

endmodule

FILE: rtl/vtpe_queue.sv
module vtpe_queue #(
	parameter int DEPTH = 2
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push_valid,
	output logic           push_ready,
	input  vtpe_pkg::job_t push_job,
	output logic           pop_valid,
	input  logic           pop_ready,
	output vtpe_pkg::job_t pop_job
);
	import vtpe_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

	job_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q, rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             push, pop;

	assign push_ready = cnt_q != CNT_FULL;
	assign pop_valid  = cnt_q != '0;
	assign pop_job    = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	// Write the entry
	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_job;
	end

	// Advance pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= (wr_ptr_q == PTR_LAST) ? '0 : wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= (rd_ptr_q == PTR_LAST) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

`ifndef ASSERT_OFF
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL) else $error("queue fill count out of range");
	a_ptr_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q == '0 || cnt_q == CNT_FULL) |-> wr_ptr_q == rd_ptr_q)
		else $error("queue pointers disagree with fill count");
	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(push && !pop) |=> cnt_q == $past(cnt_q) + 1'b1)
		else $error("queue push lost");
`endif

endmodule

FILE: rtl/vtpe_back.sv
module vtpe_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           pop_valid,
	output logic           pop_ready,
	input  vtpe_pkg::job_t pop_job,
	output logic           out_valid,
	input  logic           out_ready,
	output logic [7:0]     out_byte,
	output logic           last_byte
);
	import vtpe_pkg::*;

	logic [2:0] idx_q;
	logic       out_valid_q;
	logic [7:0] out_byte_q;
	logic       last_q;
	logic       load;
	logic       at_end;

	assign load      = !out_valid_q || out_ready;
	assign at_end    = idx_q == (pop_job.count - 3'd1);
	assign pop_ready = load && at_end;

	assign out_valid = out_valid_q;
	assign out_byte  = out_byte_q;
	assign last_byte = last_q;

	// Step through the head job, one byte per cycle unless out_ready stalls it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			idx_q       <= '0;
		end else if (load) begin
			out_valid_q <= pop_valid;
			if (pop_valid)
				idx_q <= at_end ? 3'd0 : idx_q + 3'd1;
		end
	end

	// Hold the output byte
	always_ff @(posedge clk) begin
		if (load && pop_valid) begin
			out_byte_q <= pop_job.bytes[idx_q];
			last_q     <= at_end;
		end
	end

`ifndef ASSERT_OFF
	a_idx_range: assert property (@(posedge clk) disable iff (!arst_n)
		pop_valid |-> idx_q < pop_job.count)
		else $error("byte index past end of job");
	a_idx_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_valid && pop_ready) |=> idx_q == 3'd0)
		else $error("byte index not cleared after job");
	a_last_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(load && pop_valid) |=> (last_q == $past(pop_ready)))
		else $error("last byte flag out of step with job end");
`endif

endmodule

FILE: rtl/vector_terminal_point_encoder_unit.sv
// Point-plot encoder for a vector terminal. Each item is a command: start row
// gives ESC FS (two bytes), end row gives a newline (one byte), plot point
// gives an intensity character and the compressed address (two to five
// bytes); an unused command code is taken and dropped. The output emits one
// byte per cycle unless out_ready stalls it. The front end encodes an item in
// the cycle it is taken and hands it to a queue of QUEUE_DEPTH jobs, so it
// keeps taking items while the output stalls until that queue is full. Last
// point address resets to zero.
module vector_terminal_point_encoder_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [1:0]         command,
	input  logic [9:0]         x_coord,
	input  logic [9:0]         y_coord,
	input  logic signed [12:0] intensity,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [7:0]         out_byte,
	output logic               last_byte
);
	import vtpe_pkg::*;

	logic push_valid, push_ready;
	logic pop_valid, pop_ready;
	job_t push_job, pop_job;

	// Accept and encode items
	vtpe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.command    (command),
		.x_coord    (x_coord),
		.y_coord    (y_coord),
		.intensity  (intensity),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job)
	);

	// Buffer encoded jobs
	vtpe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_job   (push_job),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_job    (pop_job)
	);

	// Serialize bytes to the output
	vtpe_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_job   (pop_job),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.last_byte (last_byte)
	);

endmodule
